/* rtl/lcc_pkg.sv */
// Shared definitions for the link count checker: widths, register indexes,
// report codes, controller states and the command and status bundles.
// No dependencies.
`default_nettype none

package lcc_pkg;

   // Defaults for the top-level parameters.
   localparam int DEF_INODE_BITS  = 16;
   localparam int DEF_COUNT_BITS  = 16;
   localparam int DEF_WATCH_SLOTS = 6;
   localparam int DEF_ROOT_INODE  = 2;

   // Fixed field widths.
   localparam int INO_W       = 16;
   localparam int LINK_W      = 16;
   localparam int TOTAL_W     = 16;
   localparam int KIND_W      = 2;
   localparam int OP_W        = 1;
   localparam int REQ_TDATA_W = 40;
   localparam int RSP_TDATA_W = 48;
   localparam int CSR_IDX_W   = 3;
   localparam int CSR_DATA_W  = 16;
   localparam int MAX_WATCH   = 6;

   // Configuration register indexes.
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_INODE = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_WATCH_A   = 3'd1;

   localparam logic [INO_W-1:0] MAX_INODE_RESET = 16'hFFFF;

   // Request kinds.
   localparam logic [OP_W-1:0] OP_ENTRY = 1'b0;
   localparam logic [OP_W-1:0] OP_CHECK = 1'b1;

   // Report kinds.
   localparam logic [KIND_W-1:0] KIND_BAD      = 2'd0;
   localparam logic [KIND_W-1:0] KIND_WATCHED  = 2'd1;
   localparam logic [KIND_W-1:0] KIND_MISMATCH = 2'd2;

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_LOOKUP,
      ST_UPDATE
   } lcc_state_type;

   typedef struct packed {
      logic load;
      logic lookup;
      logic commit;
      logic clear_step;
   } lcc_cmd_type;

   typedef struct packed {
      logic clear_last;
      logic has_result;
      logic out_free;
   } lcc_status_type;

endpackage

`default_nettype wire

/* rtl/link_count_checker_top.sv */
// Top level of the link count checker: joins the controller and datapath.
// Depends on lcc_pkg, lcc_ctrl and lcc_dpath.
`default_nettype none

// Counts directory entries per i-number and checks inode link counts.
// After reset the count memory is cleared one entry a cycle, over all
// 2^INODE_BITS entries (65536 by default); no word is accepted during that
// pass, but configuration writes are. Each word then goes through accept,
// one registered read of the count memory, and the update that writes the
// count back and loads the report. A report waits in an output register,
// so the next word is accepted while it is pending; the update stalls only
// if a second report meets a still-full output register.

module link_count_checker_top
   import lcc_pkg::*;
#(
   parameter int INODE_BITS  = DEF_INODE_BITS,
   parameter int COUNT_BITS  = DEF_COUNT_BITS,
   parameter int WATCH_SLOTS = DEF_WATCH_SLOTS,
   parameter int ROOT_INODE  = DEF_ROOT_INODE
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   csr_we,
   input  wire logic [CSR_IDX_W-1:0]   csr_index,
   input  wire logic [CSR_DATA_W-1:0]  csr_wdata,
   input  wire logic                   req_tvalid,
   output logic                        req_tready,
   // op
   input  wire logic [OP_W-1:0]        req_tuser,
   // inode_number [15:0], allocated [16], link_total [32:17], zero pad
   input  wire logic [REQ_TDATA_W-1:0] req_tdata,
   output logic                        rsp_tvalid,
   input  wire logic                   rsp_tready,
   // report_kind
   output logic [KIND_W-1:0]           rsp_tuser,
   // report_inode [15:0], entry_total [31:16], link_seen [47:32]
   output logic [RSP_TDATA_W-1:0]      rsp_tdata
);

   lcc_cmd_type    cmd;
   lcc_status_type status;

   lcc_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   lcc_dpath #(
      .INODE_BITS  (INODE_BITS),
      .COUNT_BITS  (COUNT_BITS),
      .WATCH_SLOTS (WATCH_SLOTS),
      .ROOT_INODE  (ROOT_INODE)
   ) u_dpath (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tuser  (rsp_tuser),
      .rsp_tdata  (rsp_tdata),
      .cmd        (cmd),
      .status     (status)
   );

endmodule

`default_nettype wire

/* rtl/lcc_ctrl.sv */
// Controller of the link count checker: clearing pass, then one item at a
// time through lookup and update. Depends on lcc_pkg.
`default_nettype none

module lcc_ctrl
   import lcc_pkg::*;
(
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           req_tvalid,
   output logic                req_tready,
   input  wire lcc_status_type status,
   output lcc_cmd_type         cmd
);

   lcc_state_type state_ff;
   lcc_state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      req_tready = 1'b0;
      case (state_ff)
         ST_CLEAR: begin
            cmd.clear_step = 1'b1;
            if (status.clear_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.load = 1'b1;
               state_in = ST_LOOKUP;
            end
         end
         ST_LOOKUP: begin
            cmd.lookup = 1'b1;
            state_in   = ST_UPDATE;
         end
         ST_UPDATE: begin
            // Hold the item until the output register can take its report.
            if (!status.has_result || status.out_free) begin
               cmd.commit = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

`ifndef ASSERT_OFF
   a_accept_then_lookup: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> (state_ff == ST_LOOKUP))
      else $error("accepted word did not move to lookup");

   a_commit_only_when_free: assert property (@(posedge clock) disable iff (reset)
      (cmd.commit && status.has_result) |-> status.out_free)
      else $error("report committed while output register busy");

   a_clear_ends_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CLEAR && status.clear_last) |=> (state_ff == ST_IDLE))
      else $error("clearing pass did not end in idle");
`endif

endmodule

`default_nettype wire

/* rtl/lcc_dpath.sv */
// Datapath of the link count checker: configuration registers, item
// registers, the count memory, the report decision and the output register.
// Depends on lcc_pkg.
`default_nettype none

module lcc_dpath
   import lcc_pkg::*;
#(
   parameter int INODE_BITS  = DEF_INODE_BITS,
   parameter int COUNT_BITS  = DEF_COUNT_BITS,
   parameter int WATCH_SLOTS = DEF_WATCH_SLOTS,
   parameter int ROOT_INODE  = DEF_ROOT_INODE
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   csr_we,
   input  wire logic [CSR_IDX_W-1:0]   csr_index,
   input  wire logic [CSR_DATA_W-1:0]  csr_wdata,
   input  wire logic [OP_W-1:0]        req_tuser,
   input  wire logic [REQ_TDATA_W-1:0] req_tdata,
   output logic                        rsp_tvalid,
   input  wire logic                   rsp_tready,
   output logic [KIND_W-1:0]           rsp_tuser,
   output logic [RSP_TDATA_W-1:0]      rsp_tdata,
   input  wire lcc_cmd_type            cmd,
   output lcc_status_type              status
);

   localparam int STORE_DEPTH = 1 << INODE_BITS;
   localparam int CMP_W       = (COUNT_BITS > LINK_W) ? COUNT_BITS : LINK_W;

   // Configuration registers.
   logic [INO_W-1:0] max_inode_ff;
   logic [INO_W-1:0] watch_ff [WATCH_SLOTS];

   always_ff @(posedge clock) begin
      if (reset) begin
         max_inode_ff <= MAX_INODE_RESET;
         for (int s = 0; s < WATCH_SLOTS; s++) begin
            watch_ff[s] <= '0;
         end
      end else if (csr_we) begin
         if (csr_index == CSR_MAX_INODE) begin
            max_inode_ff <= csr_wdata;
         end
         for (int s = 0; s < WATCH_SLOTS; s++) begin
            if (csr_index == CSR_WATCH_A + CSR_IDX_W'(s)) begin
               watch_ff[s] <= csr_wdata;
            end
         end
      end
   end

   // Item registers.
   logic [OP_W-1:0]       op_ff;
   logic [INO_W-1:0]      ino_ff;
   logic                  alloc_ff;
   logic [LINK_W-1:0]     link_ff;
   logic [INODE_BITS-1:0] idx_ff;

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff    <= req_tuser;
         ino_ff   <= req_tdata[15:0];
         alloc_ff <= req_tdata[16];
         link_ff  <= req_tdata[32:17];
         idx_ff   <= INODE_BITS'(req_tdata[15:0]);
      end
   end

   // Clearing counter for the pass after reset.
   logic [INODE_BITS-1:0] clr_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff <= '0;
      end else if (cmd.clear_step) begin
         clr_ff <= clr_ff + 1'b1;
      end
   end

   // Count memory: one write port, one registered read port.
   logic [COUNT_BITS-1:0] count_mem [STORE_DEPTH];
   logic [COUNT_BITS-1:0] rd_ff;
   logic                  mem_we;
   logic [INODE_BITS-1:0] mem_waddr;
   logic [COUNT_BITS-1:0] mem_wdata;
   logic [COUNT_BITS-1:0] cnt_next;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         count_mem[mem_waddr] <= mem_wdata;
      end
      if (cmd.lookup) begin
         rd_ff <= count_mem[idx_ff];
      end
   end

   // Report decision.
   logic                  is_bad;
   logic                  watched;
   logic                  count_en;
   logic                  exempt;
   logic                  has_result;
   logic [KIND_W-1:0]     kind;
   logic [CMP_W-1:0]      link_ext;
   logic [CMP_W-1:0]      cnt_ext;

   always_comb begin
      watched = 1'b0;
      for (int s = 0; s < WATCH_SLOTS; s++) begin
         if (watch_ff[s] != '0 && watch_ff[s] == ino_ff) begin
            watched = 1'b1;
         end
      end
   end

   assign is_bad   = (ino_ff > max_inode_ff) || (ino_ff <= INO_W'(1));
   assign cnt_next = (&rd_ff) ? rd_ff : rd_ff + 1'b1;
   assign link_ext = CMP_W'(link_ff);
   assign cnt_ext  = CMP_W'(rd_ff);

   // Exemptions: unallocated with no entries, nonzero counts agreeing, or a
   // reserved low i-number with neither links nor entries.
   assign exempt = (!alloc_ff && rd_ff == '0)
                || (link_ext == cnt_ext && link_ff != '0)
                || (ino_ff < INO_W'(ROOT_INODE) && link_ff == '0 && rd_ff == '0);

   always_comb begin
      count_en   = 1'b0;
      has_result = 1'b0;
      kind       = KIND_BAD;
      if (op_ff == OP_ENTRY) begin
         if (ino_ff != '0) begin
            if (is_bad) begin
               has_result = 1'b1;
               kind       = KIND_BAD;
            end else begin
               count_en   = 1'b1;
               has_result = watched;
               kind       = KIND_WATCHED;
            end
         end
      end else begin
         has_result = !exempt;
         kind       = KIND_MISMATCH;
      end
   end

   always_comb begin
      if (cmd.clear_step) begin
         mem_we    = 1'b1;
         mem_waddr = clr_ff;
         mem_wdata = '0;
      end else begin
         mem_we    = cmd.commit && count_en;
         mem_waddr = idx_ff;
         mem_wdata = cnt_next;
      end
   end

   // Output register.
   logic                   rsp_valid_ff;
   logic [KIND_W-1:0]      rsp_kind_ff;
   logic [RSP_TDATA_W-1:0] rsp_data_ff;
   logic                   out_free;

   assign out_free = !rsp_valid_ff || rsp_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.commit && has_result) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.commit && has_result) begin
         rsp_kind_ff <= kind;
         if (kind == KIND_MISMATCH) begin
            rsp_data_ff <= {link_ff, TOTAL_W'(rd_ff), ino_ff};
         end else begin
            rsp_data_ff <= {LINK_W'(0), TOTAL_W'(0), ino_ff};
         end
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_kind_ff;
   assign rsp_tdata  = rsp_data_ff;

   assign status.clear_last = &clr_ff;
   assign status.has_result = has_result;
   assign status.out_free   = out_free;

endmodule

`default_nettype wire

/* tb/sv/link_count_checker_top_tb.sv */
// Self-checking testbench for link_count_checker_top: streams entry and inode
// words into the block and compares every report word with its own predictor.
// Depends on lcc_pkg and the link_count_checker_top RTL.

module link_count_checker_top_tb;
   import lcc_pkg::*;

   localparam int CLOCK_PERIOD = 12;
   localparam longint RUN_LIMIT = 64'd1_200_000 * CLOCK_PERIOD;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE = 3'd7;
   localparam logic [TOTAL_W-1:0] COUNT_TOP = '1;
   localparam int SETTLE_CYCLES = 8;
   localparam int HOLD_CYCLES = 300;
   localparam int SHOWN_ERRORS = 10;

   typedef struct packed {
      logic [KIND_W-1:0]  kind;
      logic [INO_W-1:0]   inode;
      logic [TOTAL_W-1:0] total;
      logic [LINK_W-1:0]  link;
   } link_report_type;

   // Keeps the per-inode entry counts and the register copies, and queues the
   // report words that the block owes.
   class link_count_scoreboard;
      bit [TOTAL_W-1:0] entry_counts [2**INO_W];
      bit [INO_W-1:0]   max_inode;
      bit [INO_W-1:0]   watch_list [MAX_WATCH];
      link_report_type  owed_reports [$];
      int               mismatches;

      function new();
         max_inode = MAX_INODE_RESET;
         mismatches = 0;
      endfunction

      function void write_reg(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] value);
         if (idx == CSR_MAX_INODE)
            max_inode = value;
         else if (idx >= CSR_WATCH_A && idx < CSR_WATCH_A + MAX_WATCH)
            watch_list[idx - CSR_WATCH_A] = value;
      endfunction

      function logic [TOTAL_W-1:0] count_of(logic [INO_W-1:0] ino);
         return entry_counts[ino];
      endfunction

      function int pending();
         return owed_reports.size();
      endfunction

      function void note_request(logic [OP_W-1:0] op, logic [INO_W-1:0] ino,
                                 logic alloc, logic [LINK_W-1:0] link);
         link_report_type rep;
         bit [TOTAL_W-1:0] cnt;
         bit hit;
         rep.kind = KIND_BAD;
         rep.inode = ino;
         rep.total = '0;
         rep.link = '0;
         if (op == OP_ENTRY) begin
            if (ino == 0)
               return;
            if (ino > max_inode || ino <= 1) begin
               owed_reports.push_back(rep);
               return;
            end
            // A slot holding zero is unused; duplicates still give one report.
            hit = 1'b0;
            for (int s = 0; s < DEF_WATCH_SLOTS; s++)
               if (watch_list[s] != 0 && watch_list[s] == ino)
                  hit = 1'b1;
            if (entry_counts[ino] != COUNT_TOP)
               entry_counts[ino]++;
            if (hit) begin
               rep.kind = KIND_WATCHED;
               owed_reports.push_back(rep);
            end
            return;
         end
         cnt = entry_counts[ino];
         if (!alloc && cnt == 0)
            return;
         if (link == cnt && link != 0)
            return;
         if (ino < DEF_ROOT_INODE && link == 0 && cnt == 0)
            return;
         rep.kind = KIND_MISMATCH;
         rep.total = cnt;
         rep.link = link;
         owed_reports.push_back(rep);
      endfunction

      function void check_report(logic [KIND_W-1:0] kind, logic [RSP_TDATA_W-1:0] data);
         link_report_type got;
         link_report_type want;
         got.kind = kind;
         got.inode = data[15:0];
         got.total = data[31:16];
         got.link = data[47:32];
         if (owed_reports.size() == 0) begin
            if (mismatches < SHOWN_ERRORS)
               $display("unexpected report: kind %0d inode %0d total %0d link %0d",
                        got.kind, got.inode, got.total, got.link);
            mismatches++;
            return;
         end
         want = owed_reports.pop_front();
         if (got.kind !== want.kind || got.inode !== want.inode ||
             got.total !== want.total || got.link !== want.link) begin
            if (mismatches < SHOWN_ERRORS)
               $display("report differs: expected kind %0d inode %0d total %0d link %0d, %s",
                        want.kind, want.inode, want.total, want.link,
                        $sformatf("got kind %0d inode %0d total %0d link %0d",
                                  got.kind, got.inode, got.total, got.link));
            mismatches++;
         end
      endfunction
   endclass

   logic                   clock = 1'b0;
   logic                   reset;
   logic                   csr_we;
   logic [CSR_IDX_W-1:0]   csr_index;
   logic [CSR_DATA_W-1:0]  csr_wdata;
   logic                   req_tvalid;
   logic                   req_tready;
   logic [OP_W-1:0]        req_tuser;
   logic [REQ_TDATA_W-1:0] req_tdata;
   logic                   rsp_tvalid;
   logic                   rsp_tready;
   logic [KIND_W-1:0]      rsp_tuser;
   logic [RSP_TDATA_W-1:0] rsp_tdata;

   bit no_idle = 1'b0;
   int rsp_wait_left = 0;
   int rsp_hold_left = 0;

   link_count_scoreboard sb = new();

   link_count_checker_top dut (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tuser  (rsp_tuser),
      .rsp_tdata  (rsp_tdata)
   );

   always #(CLOCK_PERIOD / 2) clock = ~clock;

   initial begin
      #(RUN_LIMIT);
      $display("link_count_checker_top: mismatch");
      $finish;
   end

   // Result side: a long hold wins over the per-word stall.
   initial begin
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         if (rsp_hold_left > 0) begin
            rsp_tready <= 1'b0;
            rsp_hold_left--;
         end else if (rsp_wait_left > 0) begin
            rsp_tready <= 1'b0;
            rsp_wait_left--;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         sb.check_report(rsp_tuser, rsp_tdata);
         rsp_wait_left = no_idle ? 0 : $urandom_range(0, 5);
      end
   end

   task automatic csr_write(input logic [CSR_IDX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] value);
      @(negedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      sb.write_reg(idx, value);
   endtask

   // The watch list runs from watch_f in the top bits down to watch_a.
   task automatic apply_settings(input logic [INO_W-1:0] top,
                                 input logic [MAX_WATCH-1:0][INO_W-1:0] watches);
      csr_write(CSR_MAX_INODE, top);
      for (int s = 0; s < MAX_WATCH; s++)
         csr_write(CSR_WATCH_A + CSR_IDX_W'(s), watches[s]);
      csr_write(CSR_SPARE, CSR_DATA_W'($urandom()));
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   // Entered at a falling edge; returns at the falling edge after acceptance
   // with the word still offered, so the next call may keep tvalid high.
   task automatic send_word(input logic [OP_W-1:0] op, input logic [INO_W-1:0] ino,
                            input logic alloc, input logic [LINK_W-1:0] link);
      int gap;
      gap = no_idle ? 0 : $urandom_range(0, 5);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= op;
      req_tdata <= REQ_TDATA_W'({link, alloc, ino});
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      sb.note_request(op, ino, alloc, link);
      @(negedge clock);
   endtask

   // A word that gives no report may still be in flight, hence the settle time.
   task automatic wait_idle();
      req_tvalid <= 1'b0;
      while (sb.pending() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic run_random(input int words, input bit with_pressure);
      int pick;
      logic [OP_W-1:0] op;
      logic [INO_W-1:0] ino;
      logic alloc;
      logic [LINK_W-1:0] link;
      logic [TOTAL_W-1:0] cnt;
      for (int i = 0; i < words; i++) begin
         if (i % 50 == 0)
            no_idle = ($urandom_range(0, 3) == 0);
         if (with_pressure && i == 80) begin
            no_idle = 1'b1;
            rsp_hold_left = HOLD_CYCLES;
         end
         if (with_pressure && i == 160)
            wait_idle();
         op = ($urandom_range(0, 99) < 35) ? OP_CHECK : OP_ENTRY;
         pick = $urandom_range(0, 99);
         if (pick < 70)
            ino = INO_W'($urandom_range(0, 24));
         else if (pick < 80)
            ino = sb.watch_list[$urandom_range(0, MAX_WATCH - 1)];
         else if (pick < 88)
            ino = INO_W'(sb.max_inode + $urandom_range(0, 2) - 1);
         else
            ino = INO_W'($urandom());
         alloc = ($urandom_range(0, 99) < 80);
         // Link counts near the stored count reach the exemption rules.
         cnt = sb.count_of(ino);
         pick = $urandom_range(0, 99);
         if (pick < 35)
            link = cnt;
         else if (pick < 50)
            link = cnt + 1'b1;
         else if (pick < 60)
            link = cnt - 1'b1;
         else if (pick < 75)
            link = '0;
         else
            link = LINK_W'($urandom());
         send_word(op, ino, alloc, link);
      end
   endtask

   initial begin
      logic [MAX_WATCH-1:0][INO_W-1:0] random_watch;
      logic [INO_W-1:0] random_top;
      reset = 1'b1;
      csr_we = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      req_tvalid = 1'b0;
      req_tuser = '0;
      req_tdata = '0;
      repeat (3) @(negedge clock);
      reset <= 1'b0;

      // Written while the count memory is still being cleared.
      apply_settings(16'hFFFF, {16'd17, 16'd0, 16'd65535, 16'd3, 16'd3, 16'd2});
      no_idle = 1'b0;
      send_word(OP_ENTRY, 16'd0, 1'b1, 16'hFFFF);
      send_word(OP_ENTRY, 16'd1, 1'b0, 16'd0);
      send_word(OP_ENTRY, 16'd65535, 1'b0, 16'd0);
      send_word(OP_ENTRY, 16'd2, 1'b0, 16'd0);
      send_word(OP_ENTRY, 16'd3, 1'b0, 16'd0);
      send_word(OP_ENTRY, 16'd5, 1'b0, 16'd0);
      send_word(OP_ENTRY, 16'd5, 1'b1, 16'd1);
      send_word(OP_CHECK, 16'd5, 1'b1, 16'd2);
      send_word(OP_CHECK, 16'd5, 1'b1, 16'd3);
      send_word(OP_CHECK, 16'd6, 1'b0, 16'd4);
      send_word(OP_CHECK, 16'd6, 1'b1, 16'd0);
      send_word(OP_CHECK, 16'd0, 1'b1, 16'd0);
      send_word(OP_CHECK, 16'd1, 1'b1, 16'd7);
      send_word(OP_CHECK, 16'd1, 1'b1, 16'd0);
      send_word(OP_CHECK, 16'd65535, 1'b0, 16'hFFFF);
      send_word(OP_CHECK, 16'd2, 1'b1, 16'd1);
      send_word(OP_ENTRY, 16'd17, 1'b0, 16'd0);
      send_word(OP_CHECK, 16'd40000, 1'b1, 16'hFFFF);
      wait_idle();

      // Smallest volume: every nonzero entry is bad, checks still read the store.
      apply_settings(16'd1, {16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd1});
      send_word(OP_ENTRY, 16'd2, 1'b0, 16'd0);
      send_word(OP_ENTRY, 16'd65535, 1'b0, 16'd0);
      send_word(OP_ENTRY, 16'd0, 1'b0, 16'd0);
      send_word(OP_ENTRY, 16'd1, 1'b0, 16'd0);
      send_word(OP_CHECK, 16'd3, 1'b1, 16'd1);
      send_word(OP_CHECK, 16'd65535, 1'b1, 16'd1);
      wait_idle();

      apply_settings(16'd20, {16'd12, 16'd12, 16'd0, 16'd21, 16'd9, 16'd5});
      run_random(250, 1'b1);
      wait_idle();

      apply_settings(16'hFFFF, {16'd0, 16'd4, 16'd3, 16'd2, 16'd1, 16'd65535});
      run_random(250, 1'b0);
      wait_idle();

      random_top = INO_W'($urandom_range(2, 40));
      for (int s = 0; s < MAX_WATCH; s++)
         random_watch[s] = INO_W'($urandom_range(0, 30));
      apply_settings(random_top, random_watch);
      run_random(250, 1'b0);
      wait_idle();

      if (sb.mismatches == 0 && sb.pending() == 0)
         $display("link_count_checker_top: match");
      else
         $display("link_count_checker_top: mismatch");
      $finish;
   end

endmodule
